[rtl/rsep_pkg.sv]
// rsep_pkg: types, codes and constants shared by the rlp stream event parser
// no dependencies; used by every module of the parser and by its checker
package rsep_pkg;

  localparam int STACK_DEPTH = 16;
  localparam int MAX_RESULTS = 20;
  localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
  localparam int QUEUE_DEPTH = 4;

  // prefix byte boundaries
  localparam logic [7:0] PFX_SHORT_MAX   = 8'h7F;
  localparam logic [7:0] PFX_EMPTY       = 8'h80;
  localparam logic [7:0] PFX_STR_MAX     = 8'hB7;
  localparam logic [7:0] PFX_STR_LEN_MAX = 8'hBF;
  localparam logic [7:0] PFX_LIST        = 8'hC0;
  localparam logic [7:0] PFX_LIST_MAX    = 8'hF7;
  localparam logic [7:0] LEN_BYTES_MAX   = 8'd2;

  typedef enum logic [2:0] {
    K_BOTTOM   = 3'd0,
    K_LIST     = 3'd1,
    K_STR      = 3'd2,
    K_LIST_LEN = 3'd3,
    K_STR_LEN  = 3'd4
  } ctx_kind_t;

  typedef enum logic [2:0] {
    EV_LIST_START  = 3'd0,
    EV_LIST_END    = 3'd1,
    EV_BYTES_START = 3'd2,
    EV_PAYLOAD     = 3'd3,
    EV_BYTES_END   = 3'd4,
    EV_ERROR       = 3'd5
  } ev_kind_t;

  typedef enum logic [1:0] {
    ERR_TOO_LONG  = 2'd0,
    ERR_OVERFLOW  = 2'd1,
    ERR_UNDERFLOW = 2'd2,
    ERR_MALFORMED = 2'd3
  } err_t;

  // prefix class worked out by the front end
  typedef enum logic [2:0] {
    C_SHORT    = 3'd0,
    C_EMPTY    = 3'd1,
    C_STR      = 3'd2,
    C_STR_LEN  = 3'd3,
    C_LIST     = 3'd4,
    C_LIST_LEN = 3'd5,
    C_TOO_LONG = 3'd6
  } cls_t;

  typedef struct packed {
    logic       restart;
    logic [7:0] data;
    cls_t       cls;
  } q_item_t;

  typedef struct packed {
    ev_kind_t    kind;
    logic [15:0] length;
    logic [7:0]  payload;
    err_t        err;
  } ev_t;

  typedef struct packed {
    logic push;
    logic fin;
    ev_t  ev;
  } out_req_t;

  typedef enum logic [2:0] {
    BK_IDLE = 3'd0,
    BK_EMIT = 3'd1,
    BK_UPD  = 3'd2,
    BK_CAS  = 3'd3,
    BK_ERR  = 3'd4,
    BK_FIN  = 3'd5
  } bk_state_t;

  function automatic ev_t mk_ev(ev_kind_t kind, logic [15:0] len, logic [7:0] pay, err_t err);
    ev_t e;
    e.kind    = kind;
    e.length  = len;
    e.payload = pay;
    e.err     = err;
    return e;
  endfunction

endpackage

[rtl/rlp_stream_event_parser.sv]
// rlp_stream_event_parser: top level of the rlp stream event parser
// depends on rsep_pkg, rsep_front, rsep_back, rsep_out
//
//   channel | signals                                      | direction
//   in      | in_valid, in_ready, func, data_byte          | input item
//   out     | out_valid, out_ready, event_kind, length,    | one event
//           | payload, error_code, last                    |
//
// for each byte the back-end sequencer acts on the top context, requests each event it
// causes, leaves the event script, updates the list cursors, runs the cascade check and
// releases the last event. an error found before the list update skips it and the cascade.
// restart and ignored bytes are popped from the queue without that sequence. a four-entry
// queue lets bytes arrive while the sequencer works. reset is synchronous and empties the
// stack. a stalled output holds the sequencer at its next event.
module rlp_stream_event_parser #(
  parameter int STACK_DEPTH = rsep_pkg::STACK_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        func,
  input  logic [7:0]  data_byte,
  input  logic        in_valid,
  output logic        in_ready,
  output logic [2:0]  event_kind,
  output logic [15:0] length,
  output logic [7:0]  payload,
  output logic [1:0]  error_code,
  output logic        last,
  output logic        out_valid,
  input  logic        out_ready
);

  logic               q_valid, q_pop, ack;
  rsep_pkg::q_item_t  q_item;
  rsep_pkg::out_req_t req;

  rsep_front u_front (
    .clk, .rst, .func, .data_byte, .in_valid, .in_ready,
    .q_valid, .q_item, .q_pop
  );

  rsep_back #(.STACK_DEPTH(STACK_DEPTH)) u_back (
    .clk, .rst, .q_valid, .q_item, .q_pop, .req, .ack
  );

  rsep_out u_out (
    .clk, .rst, .req, .ack, .event_kind, .length, .payload, .error_code,
    .last, .out_valid, .out_ready
  );

endmodule

[rtl/rsep_front.sv]
// rsep_front: input transfer, prefix classification and a short item queue
// depends on rsep_pkg
module rsep_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               func,
  input  logic [7:0]         data_byte,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               q_valid,
  output rsep_pkg::q_item_t  q_item,
  input  logic               q_pop
);

  localparam int QD  = rsep_pkg::QUEUE_DEPTH;
  localparam int PW  = $clog2(QD);
  localparam int CW  = $clog2(QD + 1);

  rsep_pkg::q_item_t mem [QD];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;
  rsep_pkg::cls_t cls;
  logic push, pop;

  // classify the byte as a prefix, independent of parser state
  always_comb begin
    if (data_byte <= rsep_pkg::PFX_SHORT_MAX) begin
      cls = rsep_pkg::C_SHORT;
    end else if (data_byte == rsep_pkg::PFX_EMPTY) begin
      cls = rsep_pkg::C_EMPTY;
    end else if (data_byte <= rsep_pkg::PFX_STR_MAX) begin
      cls = rsep_pkg::C_STR;
    end else if (data_byte <= rsep_pkg::PFX_STR_LEN_MAX) begin
      cls = (data_byte - rsep_pkg::PFX_STR_MAX <= rsep_pkg::LEN_BYTES_MAX) ?
            rsep_pkg::C_STR_LEN : rsep_pkg::C_TOO_LONG;
    end else if (data_byte <= rsep_pkg::PFX_LIST_MAX) begin
      cls = rsep_pkg::C_LIST;
    end else begin
      cls = (data_byte - rsep_pkg::PFX_LIST_MAX <= rsep_pkg::LEN_BYTES_MAX) ?
            rsep_pkg::C_LIST_LEN : rsep_pkg::C_TOO_LONG;
    end
  end

  assign in_ready = (count != CW'(QD));
  assign push     = in_valid && in_ready;
  assign q_valid  = (count != '0);
  assign pop      = q_pop && q_valid;
  assign q_item   = mem[rd_ptr];

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= '{restart: func, data: data_byte, cls: cls};
    end
  end

  // queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= PW'(wr_ptr + 1'b1);
      if (pop) rd_ptr <= PW'(rd_ptr + 1'b1);
      if (push && !pop) begin
        count <= CW'(count + 1'b1);
      end else if (pop && !push) begin
        count <= CW'(count - 1'b1);
      end
    end
  end

endmodule

[rtl/rsep_out.sv]
// rsep_out: one-event hold stage that marks the last event, and output register
// depends on rsep_pkg
module rsep_out (
  input  logic               clk,
  input  logic               rst,
  input  rsep_pkg::out_req_t req,
  output logic               ack,
  output logic [2:0]         event_kind,
  output logic [15:0]        length,
  output logic [7:0]         payload,
  output logic [1:0]         error_code,
  output logic               last,
  output logic               out_valid,
  input  logic               out_ready
);

  rsep_pkg::ev_t hold;
  logic hold_v, out_free, load, load_last;

  assign out_free  = !out_valid || out_ready;
  assign ack       = !hold_v || out_free;
  assign load      = hold_v && out_free && (req.push || req.fin);
  assign load_last = req.fin;

  // hold register
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_v <= 1'b0;
    end else if (req.push && ack) begin
      hold_v <= 1'b1;
    end else if (req.fin && ack) begin
      hold_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.push && ack) hold <= req.ev;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      event_kind <= hold.kind;
      length     <= hold.length;
      payload    <= hold.payload;
      error_code <= hold.err;
      last       <= load_last;
    end
  end

endmodule

[rtl/rsep_back.sv]
// rsep_back: context stack, per-byte sequencer, list cursor update and pop cascade
// depends on rsep_pkg
module rsep_back #(
  parameter int STACK_DEPTH = rsep_pkg::STACK_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  input  rsep_pkg::q_item_t  q_item,
  output logic               q_pop,
  output rsep_pkg::out_req_t req,
  input  logic               ack
);

  localparam int TW = $clog2(STACK_DEPTH + 1);
  localparam int CW = rsep_pkg::CNT_W;

  rsep_pkg::ctx_kind_t kind   [STACK_DEPTH+1];
  logic [15:0]         size   [STACK_DEPTH+1];
  logic [15:0]         cursor [STACK_DEPTH+1];
  logic [TW-1:0]       top;
  logic                halted;

  rsep_pkg::bk_state_t state, state_next;
  rsep_pkg::ev_t       evq [4];
  logic [2:0]          evq_n;
  logic                err_pend;
  rsep_pkg::err_t      err_code;
  logic [STACK_DEPTH:0] done_vec;
  logic [CW-1:0]       cnt;
  logic                drop, go;

  // first phase results
  rsep_pkg::ev_t       a_ev [4];
  logic [2:0]          a_n;
  logic                a_err;
  rsep_pkg::err_t      a_code;
  logic                w_en, p_en;
  rsep_pkg::ctx_kind_t w_kind, p_kind;
  logic [15:0]         w_size, w_cur, p_size;
  logic [TW-1:0]       top_a;
  logic                take;

  // first phase: act on the top context and the byte's prefix class
  always_comb begin
    rsep_pkg::ctx_kind_t tk;
    logic [15:0] ts, tc, nc;
    logic [7:0]  b;
    logic        do_str, do_pfx, full;
    tk = kind[top];
    ts = size[top];
    tc = cursor[top];
    b  = q_item.data;
    full = (top >= TW'(STACK_DEPTH));
    for (int i = 0; i < 4; i++) a_ev[i] = '0;
    a_n    = '0;
    a_err  = 1'b0;
    a_code = rsep_pkg::ERR_TOO_LONG;
    w_en   = 1'b0;
    w_kind = tk;
    w_size = ts;
    w_cur  = tc;
    p_en   = 1'b0;
    p_kind = rsep_pkg::K_STR;
    p_size = '0;
    top_a  = top;
    do_str = 1'b0;
    do_pfx = 1'b0;
    nc     = '0;
    case (tk)
      rsep_pkg::K_LIST_LEN, rsep_pkg::K_STR_LEN: begin
        w_en = 1'b1;
        if (ts == '0) begin
          // length complete: turn into an open list or byte array
          w_size = tc;
          w_cur  = '0;
          if (tk == rsep_pkg::K_LIST_LEN) begin
            w_kind = rsep_pkg::K_LIST;
            a_ev[a_n[1:0]] = rsep_pkg::mk_ev(rsep_pkg::EV_LIST_START, tc, 8'd0,
                                             rsep_pkg::ERR_TOO_LONG);
            do_pfx = 1'b1;
          end else begin
            w_kind = rsep_pkg::K_STR;
            a_ev[a_n[1:0]] = rsep_pkg::mk_ev(rsep_pkg::EV_BYTES_START, tc, 8'd0,
                                             rsep_pkg::ERR_TOO_LONG);
            do_str = 1'b1;
          end
          a_n = a_n + 3'd1;
        end else begin
          // shift in one more length byte
          w_size = ts - 16'd1;
          w_cur  = {tc[7:0], b};
          if (w_size == '0 && w_cur == '0) begin
            a_err  = 1'b1;
            a_code = rsep_pkg::ERR_MALFORMED;
          end
        end
      end
      rsep_pkg::K_STR: begin
        do_str = 1'b1;
      end
      default: begin
        do_pfx = 1'b1;
      end
    endcase
    // payload byte of an open byte array
    if (do_str) begin
      a_ev[a_n[1:0]] = rsep_pkg::mk_ev(rsep_pkg::EV_PAYLOAD, 16'd0, b, rsep_pkg::ERR_TOO_LONG);
      a_n = a_n + 3'd1;
      nc = w_cur + 16'd1;
      w_en  = 1'b1;
      w_cur = nc;
      if (nc == w_size) begin
        a_ev[a_n[1:0]] = rsep_pkg::mk_ev(rsep_pkg::EV_BYTES_END, 16'd0, 8'd0,
                                         rsep_pkg::ERR_TOO_LONG);
        a_n = a_n + 3'd1;
        top_a = TW'(top - 1'b1);
      end
    end
    // new item prefix
    if (do_pfx) begin
      case (q_item.cls)
        rsep_pkg::C_SHORT: begin
          a_ev[a_n[1:0]] = rsep_pkg::mk_ev(rsep_pkg::EV_BYTES_START, 16'd1, 8'd0,
                                           rsep_pkg::ERR_TOO_LONG);
          a_n = a_n + 3'd1;
          a_ev[a_n[1:0]] = rsep_pkg::mk_ev(rsep_pkg::EV_PAYLOAD, 16'd0, b,
                                           rsep_pkg::ERR_TOO_LONG);
          a_n = a_n + 3'd1;
          a_ev[a_n[1:0]] = rsep_pkg::mk_ev(rsep_pkg::EV_BYTES_END, 16'd0, 8'd0,
                                           rsep_pkg::ERR_TOO_LONG);
          a_n = a_n + 3'd1;
        end
        rsep_pkg::C_EMPTY: begin
          a_ev[a_n[1:0]] = rsep_pkg::mk_ev(rsep_pkg::EV_BYTES_START, 16'd0, 8'd0,
                                           rsep_pkg::ERR_TOO_LONG);
          a_n = a_n + 3'd1;
          a_ev[a_n[1:0]] = rsep_pkg::mk_ev(rsep_pkg::EV_BYTES_END, 16'd0, 8'd0,
                                           rsep_pkg::ERR_TOO_LONG);
          a_n = a_n + 3'd1;
        end
        rsep_pkg::C_TOO_LONG: begin
          a_err  = 1'b1;
          a_code = rsep_pkg::ERR_TOO_LONG;
        end
        default: begin
          // every remaining class pushes a context unless the stack is full
          if (full) begin
            a_err  = 1'b1;
            a_code = rsep_pkg::ERR_OVERFLOW;
          end else begin
            p_en  = 1'b1;
            top_a = TW'(top + 1'b1);
            case (q_item.cls)
              rsep_pkg::C_STR: begin
                p_kind = rsep_pkg::K_STR;
                p_size = {8'd0, 8'(b - rsep_pkg::PFX_EMPTY)};
                a_ev[a_n[1:0]] = rsep_pkg::mk_ev(rsep_pkg::EV_BYTES_START, p_size, 8'd0,
                                                 rsep_pkg::ERR_TOO_LONG);
                a_n = a_n + 3'd1;
              end
              rsep_pkg::C_STR_LEN: begin
                p_kind = rsep_pkg::K_STR_LEN;
                p_size = {8'd0, 8'(b - rsep_pkg::PFX_STR_MAX)};
              end
              rsep_pkg::C_LIST: begin
                p_kind = rsep_pkg::K_LIST;
                p_size = {8'd0, 8'(b - rsep_pkg::PFX_LIST)} + 16'd1;
                a_ev[a_n[1:0]] = rsep_pkg::mk_ev(rsep_pkg::EV_LIST_START,
                                                 {8'd0, 8'(b - rsep_pkg::PFX_LIST)}, 8'd0,
                                                 rsep_pkg::ERR_TOO_LONG);
                a_n = a_n + 3'd1;
              end
              default: begin
                p_kind = rsep_pkg::K_LIST_LEN;
                p_size = {8'd0, 8'(b - rsep_pkg::PFX_LIST_MAX)};
              end
            endcase
          end
        end
      endcase
    end
  end

  assign drop = (cnt >= CW'(rsep_pkg::MAX_RESULTS));
  assign take = (state == rsep_pkg::BK_IDLE) && q_valid && !q_item.restart && !halted;

  // sequencer next state and event requests
  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    req        = '0;
    go         = 1'b0;
    case (state)
      rsep_pkg::BK_IDLE: begin
        q_pop = q_valid;
        if (take) state_next = rsep_pkg::BK_EMIT;
      end
      rsep_pkg::BK_EMIT: begin
        if (evq_n == '0) begin
          state_next = err_pend ? rsep_pkg::BK_ERR : rsep_pkg::BK_UPD;
        end else begin
          req.push = !drop;
          req.ev   = evq[0];
          go       = drop || ack;
        end
      end
      rsep_pkg::BK_UPD: begin
        state_next = rsep_pkg::BK_CAS;
      end
      rsep_pkg::BK_CAS: begin
        if (done_vec[top]) begin
          req.push = !drop;
          req.ev   = rsep_pkg::mk_ev(rsep_pkg::EV_LIST_END, 16'd0, 8'd0,
                                     rsep_pkg::ERR_TOO_LONG);
          go       = drop || ack;
        end else if (|done_vec) begin
          state_next = rsep_pkg::BK_ERR;
        end else begin
          state_next = rsep_pkg::BK_FIN;
        end
      end
      rsep_pkg::BK_ERR: begin
        req.push = !drop;
        req.ev   = rsep_pkg::mk_ev(rsep_pkg::EV_ERROR, 16'd0, 8'd0, err_code);
        go       = drop || ack;
        if (go) state_next = rsep_pkg::BK_FIN;
      end
      rsep_pkg::BK_FIN: begin
        req.fin = 1'b1;
        if (ack) state_next = rsep_pkg::BK_IDLE;
      end
      default: begin
        state_next = rsep_pkg::BK_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rsep_pkg::BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      top    <= '0;
      halted <= 1'b0;
      evq_n  <= '0;
      cnt    <= '0;
    end else begin
      if (state == rsep_pkg::BK_IDLE && q_valid && q_item.restart) begin
        top    <= '0;
        halted <= 1'b0;
      end
      if (take) begin
        top   <= top_a;
        evq_n <= a_n;
        cnt   <= '0;
      end
      if (go && !drop) cnt <= CW'(cnt + 1'b1);
      if (state == rsep_pkg::BK_EMIT && go) evq_n <= evq_n - 3'd1;
      if (state == rsep_pkg::BK_CAS && go) top <= TW'(top - 1'b1);
      if (state == rsep_pkg::BK_ERR && go) halted <= 1'b1;
    end
  end

  // event script, error code and done flags
  always_ff @(posedge clk) begin
    if (take) begin
      evq      <= a_ev;
      err_pend <= a_err;
      err_code <= a_code;
    end
    if (state == rsep_pkg::BK_EMIT && go) begin
      evq[0] <= evq[1];
      evq[1] <= evq[2];
      evq[2] <= evq[3];
    end
    if (state == rsep_pkg::BK_CAS && !done_vec[top] && (|done_vec)) begin
      err_code <= rsep_pkg::ERR_MALFORMED;
    end
    if (state == rsep_pkg::BK_CAS && go) done_vec[top] <= 1'b0;
    if (state == rsep_pkg::BK_UPD) begin
      done_vec[0] <= 1'b0;
      for (int i = 1; i <= STACK_DEPTH; i++) begin
        done_vec[i] <= (TW'(i) <= top) && (kind[i] == rsep_pkg::K_LIST) &&
                       (cursor[i] + 16'd1 == size[i]);
      end
    end
  end

  // context stack: top entry update, push, parallel list cursor advance
  always_ff @(posedge clk) begin
    if (rst) begin
      kind[0]   <= rsep_pkg::K_BOTTOM;
      size[0]   <= '0;
      cursor[0] <= '0;
    end else begin
      if (take && w_en) begin
        kind[top]   <= w_kind;
        size[top]   <= w_size;
        cursor[top] <= w_cur;
      end
      if (take && p_en) begin
        kind[top_a]   <= p_kind;
        size[top_a]   <= p_size;
        cursor[top_a] <= '0;
      end
      if (state == rsep_pkg::BK_UPD) begin
        for (int i = 1; i <= STACK_DEPTH; i++) begin
          if ((TW'(i) <= top) && (kind[i] == rsep_pkg::K_LIST)) begin
            cursor[i] <= cursor[i] + 16'd1;
          end
        end
      end
    end
  end

endmodule

[rtl/rsep_checker.sv]
// rsep_checker: port-level assertions for the rlp stream event parser, with bind
// depends on rsep_pkg and rlp_stream_event_parser
module rsep_checker (
  input logic        clk,
  input logic        rst,
  input logic [2:0]  event_kind,
  input logic [15:0] length,
  input logic [7:0]  payload,
  input logic [1:0]  error_code,
  input logic        last,
  input logic        out_valid,
  input logic        out_ready
);

  // a stalled event holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(event_kind) && $stable(last))
    else $error("output event changed while stalled");

  // an error closes the burst
  a_err_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && event_kind == 3'(rsep_pkg::EV_ERROR) |-> last)
    else $error("error event not last");

  // length only on start events
  a_len: assert property (@(posedge clk) disable iff (rst)
    out_valid && event_kind != 3'(rsep_pkg::EV_LIST_START) &&
    event_kind != 3'(rsep_pkg::EV_BYTES_START) |-> length == 16'd0)
    else $error("length on non-start event");

  // payload only on payload events
  a_pay: assert property (@(posedge clk) disable iff (rst)
    out_valid && event_kind != 3'(rsep_pkg::EV_PAYLOAD) |-> payload == 8'd0)
    else $error("payload on non-payload event");

  // error code only on error events
  a_code: assert property (@(posedge clk) disable iff (rst)
    out_valid && event_kind != 3'(rsep_pkg::EV_ERROR) |-> error_code == 2'd0)
    else $error("error code on non-error event");

endmodule

bind rlp_stream_event_parser rsep_checker u_rsep_checker (
  .clk, .rst, .event_kind, .length, .payload, .error_code, .last,
  .out_valid, .out_ready
);

[verif/rlp_stream_event_parser_tb.sv]
// rlp_stream_event_parser_tb: self-checking bench for the rlp stream event parser
// depends on rsep_pkg and rlp_stream_event_parser; predicts every event burst
// in a local stack model and checks each output transfer in order
module rlp_stream_event_parser_tb;

  typedef struct {
    bit       func;
    bit [7:0] b;
    bit       drain;
  } byte_item_t;

  typedef struct {
    rsep_pkg::ev_kind_t kind;
    logic [15:0]        len;
    logic [7:0]         pay;
    rsep_pkg::err_t     err;
    bit                 last;
  } event_t;

  typedef bit [7:0] byte_q_t[$];

  logic        clk;
  logic        rst;
  logic        func;
  logic [7:0]  data_byte;
  logic        in_valid;
  logic        in_ready;
  logic [2:0]  event_kind;
  logic [15:0] length;
  logic [7:0]  payload;
  logic [1:0]  error_code;
  logic        last;
  logic        out_valid;
  logic        out_ready;

  byte_item_t pending_bytes[$];
  event_t     expected_events[$];
  event_t     burst[$];

  // parser model state
  rsep_pkg::ctx_kind_t m_kind[0:rsep_pkg::STACK_DEPTH];
  logic [15:0]         m_size[0:rsep_pkg::STACK_DEPTH];
  logic [15:0]         m_cur[0:rsep_pkg::STACK_DEPTH];
  int                  m_top;
  bit                  m_halt;

  int  mismatches = 0;
  bit  took = 0;
  int  in_idle = 0;
  int  out_idle = 0;
  int  drain_hold = 0;

  rlp_stream_event_parser dut (
    .clk(clk), .rst(rst), .func(func), .data_byte(data_byte),
    .in_valid(in_valid), .in_ready(in_ready),
    .event_kind(event_kind), .length(length), .payload(payload),
    .error_code(error_code), .last(last),
    .out_valid(out_valid), .out_ready(out_ready)
  );

  always begin
    clk = 1'b1; #2;
    clk = 1'b0; #2;
  end

  // ---- parser model ----
  function automatic void clear_model();
    for (int i = 0; i <= rsep_pkg::STACK_DEPTH; i++) begin
      m_kind[i] = rsep_pkg::K_BOTTOM;
      m_size[i] = '0;
      m_cur[i]  = '0;
    end
    m_top = 0;
  endfunction

  function automatic void emit(rsep_pkg::ev_kind_t k, logic [15:0] len, logic [7:0] pay,
                               rsep_pkg::err_t err);
    event_t ev;
    if (burst.size() >= rsep_pkg::MAX_RESULTS) return;
    ev.kind = k; ev.len = len; ev.pay = pay; ev.err = err; ev.last = 0;
    burst.push_back(ev);
  endfunction

  function automatic int push_ctx(rsep_pkg::ctx_kind_t k, logic [15:0] sz);
    if (m_top >= rsep_pkg::STACK_DEPTH) return rsep_pkg::ERR_OVERFLOW;
    m_top++;
    m_kind[m_top] = k;
    m_size[m_top] = sz;
    m_cur[m_top]  = '0;
    return -1;
  endfunction

  function automatic int pop_ctx();
    if (m_top == 0) return rsep_pkg::ERR_UNDERFLOW;
    if (m_kind[m_top] == rsep_pkg::K_LIST)
      emit(rsep_pkg::EV_LIST_END, 0, 0, rsep_pkg::ERR_TOO_LONG);
    else if (m_kind[m_top] == rsep_pkg::K_STR)
      emit(rsep_pkg::EV_BYTES_END, 0, 0, rsep_pkg::ERR_TOO_LONG);
    m_top--;
    return -1;
  endfunction

  function automatic int new_item(logic [7:0] b);
    int e;
    if (b <= rsep_pkg::PFX_SHORT_MAX) begin
      emit(rsep_pkg::EV_BYTES_START, 1, 0, rsep_pkg::ERR_TOO_LONG);
      emit(rsep_pkg::EV_PAYLOAD, 0, b, rsep_pkg::ERR_TOO_LONG);
      emit(rsep_pkg::EV_BYTES_END, 0, 0, rsep_pkg::ERR_TOO_LONG);
      return -1;
    end
    if (b == rsep_pkg::PFX_EMPTY) begin
      emit(rsep_pkg::EV_BYTES_START, 0, 0, rsep_pkg::ERR_TOO_LONG);
      emit(rsep_pkg::EV_BYTES_END, 0, 0, rsep_pkg::ERR_TOO_LONG);
      return -1;
    end
    if (b <= rsep_pkg::PFX_STR_MAX) begin
      e = push_ctx(rsep_pkg::K_STR, 16'(b - rsep_pkg::PFX_EMPTY));
      if (e < 0)
        emit(rsep_pkg::EV_BYTES_START, 16'(b - rsep_pkg::PFX_EMPTY), 0,
             rsep_pkg::ERR_TOO_LONG);
      return e;
    end
    if (b <= rsep_pkg::PFX_STR_LEN_MAX) begin
      if (b - rsep_pkg::PFX_STR_MAX > rsep_pkg::LEN_BYTES_MAX) return rsep_pkg::ERR_TOO_LONG;
      return push_ctx(rsep_pkg::K_STR_LEN, 16'(b - rsep_pkg::PFX_STR_MAX));
    end
    if (b <= rsep_pkg::PFX_LIST_MAX) begin
      // size includes the prefix byte, counted by the list update
      e = push_ctx(rsep_pkg::K_LIST, 16'(b - rsep_pkg::PFX_LIST + 1));
      if (e < 0)
        emit(rsep_pkg::EV_LIST_START, 16'(b - rsep_pkg::PFX_LIST), 0,
             rsep_pkg::ERR_TOO_LONG);
      return e;
    end
    if (b - rsep_pkg::PFX_LIST_MAX > rsep_pkg::LEN_BYTES_MAX) return rsep_pkg::ERR_TOO_LONG;
    return push_ctx(rsep_pkg::K_LIST_LEN, 16'(b - rsep_pkg::PFX_LIST_MAX));
  endfunction

  function automatic int str_byte(logic [7:0] b);
    emit(rsep_pkg::EV_PAYLOAD, 0, b, rsep_pkg::ERR_TOO_LONG);
    m_cur[m_top] = m_cur[m_top] + 16'd1;
    if (m_cur[m_top] == m_size[m_top]) return pop_ctx();
    return -1;
  endfunction

  function automatic int advance_lists();
    int e;
    for (int ix = m_top; ix >= 0; ix--) begin
      if (m_kind[ix] != rsep_pkg::K_LIST) continue;
      m_cur[ix] = m_cur[ix] + 16'd1;
      if (m_cur[ix] == m_size[ix]) begin
        if (ix != m_top) return rsep_pkg::ERR_MALFORMED;
        e = pop_ctx();
        if (e >= 0) return e;
      end
    end
    return -1;
  endfunction

  function automatic void predict_byte(bit f, logic [7:0] b);
    int e;
    bit is_list;
    e = -1;
    burst.delete();
    if (f) begin
      clear_model();
      m_halt = 0;
      return;
    end
    if (m_halt) return;
    case (m_kind[m_top])
      rsep_pkg::K_LIST_LEN, rsep_pkg::K_STR_LEN: begin
        if (m_size[m_top] == 0) begin
          is_list = (m_kind[m_top] == rsep_pkg::K_LIST_LEN);
          m_size[m_top] = m_cur[m_top];
          m_cur[m_top] = '0;
          if (is_list) begin
            m_kind[m_top] = rsep_pkg::K_LIST;
            emit(rsep_pkg::EV_LIST_START, m_size[m_top], 0, rsep_pkg::ERR_TOO_LONG);
            e = new_item(b);
          end else begin
            m_kind[m_top] = rsep_pkg::K_STR;
            emit(rsep_pkg::EV_BYTES_START, m_size[m_top], 0, rsep_pkg::ERR_TOO_LONG);
            e = str_byte(b);
          end
        end else begin
          m_size[m_top] = m_size[m_top] - 16'd1;
          m_cur[m_top] = {m_cur[m_top][7:0], b};
          // zero long-form length
          if (m_size[m_top] == 0 && m_cur[m_top] == 0) e = rsep_pkg::ERR_MALFORMED;
        end
      end
      rsep_pkg::K_STR: e = str_byte(b);
      default: e = new_item(b);
    endcase
    if (e < 0) e = advance_lists();
    if (e >= 0) begin
      emit(rsep_pkg::EV_ERROR, 0, 0, rsep_pkg::err_t'(e));
      m_halt = 1;
    end
    if (burst.size() > 0) burst[burst.size()-1].last = 1;
    foreach (burst[i]) expected_events.push_back(burst[i]);
  endfunction

  // ---- stimulus helpers ----
  function automatic void put(bit f, logic [7:0] b, bit drain = 0);
    byte_item_t it;
    it.func = f; it.b = b; it.drain = drain;
    pending_bytes.push_back(it);
  endfunction

  function automatic void put_seq(byte_q_t q);
    foreach (q[i]) put(0, q[i]);
  endfunction

  // random well-formed item, small sizes mostly
  function automatic void gen_item(int depth, ref byte_q_t q);
    byte_q_t c;
    int sel, n;
    sel = $urandom_range(0, 9);
    if (depth >= 4 && sel >= 6) sel = 0;
    if (sel <= 1) begin
      q.push_back(8'($urandom_range(0, 127)));
    end else if (sel <= 4) begin
      n = $urandom_range(0, 5);
      q.push_back(8'(rsep_pkg::PFX_EMPTY + n));
      repeat (n) q.push_back(8'($urandom_range(0, 255)));
    end else if (sel == 5) begin
      n = $urandom_range(1, 70);
      q.push_back(8'(rsep_pkg::PFX_STR_MAX + 1));
      q.push_back(8'(n));
      repeat (n) q.push_back(8'($urandom_range(0, 255)));
    end else begin
      n = $urandom_range(0, 3);
      repeat (n) gen_item(depth + 1, c);
      if (c.size() <= 55 && $urandom_range(0, 3) != 0) begin
        q.push_back(8'(rsep_pkg::PFX_LIST + c.size()));
      end else if (c.size() < 256 && $urandom_range(0, 1)) begin
        q.push_back(8'(rsep_pkg::PFX_LIST_MAX + 1));
        q.push_back(8'(c.size()));
      end else begin
        q.push_back(8'(rsep_pkg::PFX_LIST_MAX + 2));
        q.push_back(8'(c.size() >> 8));
        q.push_back(8'(c.size()));
      end
      foreach (c[i]) q.push_back(c[i]);
    end
  endfunction

  initial begin
    byte_q_t q;
    int r;
    func = 0; data_byte = 0; in_valid = 0; out_ready = 0;
    clear_model();
    m_halt = 0;
    // directed: singles, strings, lists, long forms
    put_seq('{8'h00, 8'h7F, 8'h80, 8'h81, 8'hFF, 8'hB8, 8'h01, 8'hA5});
    put_seq('{8'hC0, 8'hC2, 8'h01, 8'h02});
    // zero long-form length, then ignored byte while halted
    put_seq('{8'hB9, 8'h00, 8'h00, 8'h11});
    put(1, 8'h00);
    put_seq('{8'hF8, 8'h00});
    put(1, 8'hFF);
    // length field too wide
    put(0, 8'hBA); put(1, 8'h00); put(0, 8'hFA); put(1, 8'h00, 1);
    // inner string finishing the outer list early
    put_seq('{8'hC1, 8'h82, 8'hAA, 8'hBB});
    put(1, 8'h00);
    // stack overflow
    repeat (rsep_pkg::STACK_DEPTH + 1) put(0, 8'hF7);
    put(1, 8'h00);
    // random: mostly well-formed items, some noise and restarts
    while (pending_bytes.size() < 150) begin
      r = $urandom_range(0, 9);
      if (r == 0) begin
        repeat ($urandom_range(1, 4)) put(0, 8'($urandom_range(0, 255)));
      end else if (r == 1) begin
        put(1, 8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
      end else begin
        q.delete();
        gen_item(0, q);
        // occasionally truncate
        if (r == 2 && q.size() > 1) q = q[0:q.size()-2];
        put_seq(q);
      end
    end
    rst = 1;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 0;
    wait (pending_bytes.size() == 0 && !in_valid);
    wait (expected_events.size() == 0);
    repeat (120) @(posedge clk);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("CHECKS FAILED");
    $finish;
  end

  // input transfer: update the model
  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) begin
      predict_byte(func, data_byte);
      took <= 1;
    end
  end

  // input driver
  always @(negedge clk) begin
    if (!rst && !(in_valid && !took)) begin
      if (in_idle > 0) begin
        in_idle <= in_idle - 1;
        in_valid <= 0;
      end else if (pending_bytes.size() == 0) begin
        in_valid <= 0;
      end else if (pending_bytes[0].drain &&
                   (expected_events.size() != 0 || drain_hold < 60)) begin
        // hold until every expected event is out and the parser settles
        in_valid <= 0;
        drain_hold <= (expected_events.size() != 0) ? 0 : drain_hold + 1;
      end else if (pending_bytes.size() > 40 && $urandom_range(0, 7) == 0) begin
        in_idle <= $urandom_range(0, 10);
        in_valid <= 0;
      end else begin
        func <= pending_bytes[0].func;
        data_byte <= pending_bytes[0].b;
        in_valid <= 1;
        drain_hold <= 0;
        void'(pending_bytes.pop_front());
      end
    end
    took <= 0;
  end

  // output ready with random stall bursts
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 0;
    end else if (out_idle > 0) begin
      out_idle <= out_idle - 1;
      out_ready <= 0;
    end else if (pending_bytes.size() > 40 && $urandom_range(0, 7) == 0) begin
      out_idle <= $urandom_range(0, 10);
      out_ready <= 0;
    end else begin
      out_ready <= 1;
    end
  end

  // output check against the oldest expected event
  always @(posedge clk) begin
    event_t ev;
    if (!rst && out_valid && out_ready) begin
      if (expected_events.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected event kind=%0d len=%0d pay=%0h err=%0d last=%0b",
                   event_kind, length, payload, error_code, last);
      end else begin
        ev = expected_events.pop_front();
        if (event_kind !== ev.kind || length !== ev.len || payload !== ev.pay ||
            error_code !== ev.err || last !== ev.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch exp kind=%0d len=%0d pay=%0h err=%0d last=%0b",
                      " got kind=%0d len=%0d pay=%0h err=%0d last=%0b"},
                     ev.kind, ev.len, ev.pay, ev.err, ev.last,
                     event_kind, length, payload, error_code, last);
        end
      end
    end
  end

endmodule
